// ----- src/assert_macros.svh -----
// Assertion macros shared by the hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Invariant checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`endif

// ----- src/sha_pkg.sv -----
// Package: SHA-256 constants, types and round functions.
`default_nettype none
package sha_pkg;
  localparam int unsigned QDepth = 2;

  typedef logic [31:0] word_t;

  // Request passed from the byte front end to the compression back end.
  typedef struct packed {
    logic [511:0] block;
    logic         emit;
  } blk_req_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_ROUND,
    BE_FOLD,
    BE_EMIT
  } be_state_t;

  typedef enum logic [1:0] {
    FE_TAKE,
    FE_PAD1,
    FE_PAD2
  } fe_state_t;

  localparam word_t Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    begin
      case (r)
        6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// ----- src/sha256_byte_stream_hasher.sv -----
// Top level: SHA-256 hasher over a byte stream.
//   channel | direction | fields
//   in_     | input     | data_byte[8], byte_valid, last_byte
//   out_    | output    | digest_word[32], word_index[3], last_word
// While packing, the front takes a byte whenever the block queue has room; each
// full block runs through the compression core (load, 64 rounds, fold), which sets the sustained rate.
// A two-entry block queue lets the front keep packing while the core runs.
// A final item costs one or two padded blocks, then 8 digest words.
// Synchronous active-low reset loads the initial hash and empties the queue.
`default_nettype none
module sha256_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_last_byte,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word,
  output logic             out_valid,
  input  wire logic        out_ready
);
  import sha_pkg::*;

  blk_req_t req;
  logic     req_valid, req_ready;

  sha_front u_front (
    .clk, .rst_n, .in_data_byte, .in_byte_valid, .in_last_byte,
    .in_valid, .in_ready, .req, .req_valid, .req_ready
  );

  sha_core u_core (
    .clk, .rst_n, .req, .req_valid, .req_ready,
    .out_digest_word, .out_word_index, .out_last_word, .out_valid, .out_ready
  );
endmodule
`default_nettype wire

// ----- src/sha_front.sv -----
// Front end: packs bytes into blocks, pads, and queues block requests.
`default_nettype none
module sha_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_byte_valid,
  input  wire logic              in_last_byte,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output sha_pkg::blk_req_t      req,
  output logic                   req_valid,
  input  wire logic              req_ready
);
  import sha_pkg::*;

  fe_state_t     st_r, st_nxt;
  logic [511:0]  blk_r, blk_nxt;
  logic [5:0]    fill_r, fill_nxt;
  logic [63:0]   bits_r, bits_nxt;
  logic [63:0]   total_r, total_nxt;
  logic          push;
  blk_req_t      push_req;

  // queue between front and back
  blk_req_t                    q_r [QDepth];
  logic [$clog2(QDepth):0]     cnt_r;
  logic [$clog2(QDepth)-1:0]   wp_r, rp_r;
  logic                        q_full, pop;

  assign q_full    = (cnt_r == ($clog2(QDepth)+1)'(QDepth));
  assign req_valid = (cnt_r != '0);
  assign req       = q_r[rp_r];
  assign pop       = req_valid && req_ready;

  // Build blocks from bytes and padding
  always_comb begin
    logic [511:0] b;
    logic [5:0]   f;
    logic [63:0]  tot;
    b = blk_r; f = fill_r; tot = 64'd0;
    st_nxt = st_r; blk_nxt = blk_r; fill_nxt = fill_r; bits_nxt = bits_r;
    total_nxt = total_r; push = 1'b0; push_req = '0;
    in_ready = 1'b0;
    unique case (st_r)
      FE_TAKE: begin
        in_ready = !q_full;
        if (in_valid && !q_full) begin
          if (in_byte_valid) begin
            b[511 - 8*f -: 8] = in_data_byte;
            if (f == 6'd63) begin
              push = 1'b1; push_req.block = b; push_req.emit = 1'b0;
              bits_nxt = bits_r + 64'd512;
            end
            f = f + 6'd1;
          end
          blk_nxt = b; fill_nxt = f;
          if (in_last_byte) begin
            tot = (push ? bits_r + 64'd512 : bits_r) + {55'd0, f, 3'd0};
            total_nxt = tot;
            st_nxt = FE_PAD1;
          end
        end
      end
      FE_PAD1: begin
        // place 0x80 and zero the rest; length if it fits
        for (int i = 0; i < 64; i++) begin
          if (6'(i) == fill_r) b[511-8*i -: 8] = 8'h80;
          else if (6'(i) > fill_r) b[511-8*i -: 8] = 8'h00;
        end
        if (fill_r < 6'd56) begin
          b[63:0] = total_r;
          push_req.emit = 1'b1;
        end
        push_req.block = b;
        if (!q_full) begin
          push = 1'b1;
          if (fill_r < 6'd56) begin
            st_nxt = FE_TAKE; fill_nxt = '0; bits_nxt = '0;
          end else begin
            st_nxt = FE_PAD2;
          end
        end
      end
      FE_PAD2: begin
        push_req.block = {448'd0, total_r};
        push_req.emit  = 1'b1;
        if (!q_full) begin
          push = 1'b1; st_nxt = FE_TAKE; fill_nxt = '0; bits_nxt = '0;
        end
      end
      default: st_nxt = FE_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FE_TAKE; fill_r <= '0; bits_r <= '0;
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; bits_r <= bits_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt; total_r <= total_nxt;
    if (push) q_r[wp_r] <= push_req;
  end

  `include "assert_macros.svh"
  `ASSERT_IMP(a_no_push_full, clk, rst_n, q_full && !pop, !push)
  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= ($clog2(QDepth)+1)'(QDepth))
  `ASSERT_IMP(a_pad_closes, clk, rst_n, st_r == FE_PAD2 && push, st_nxt == FE_TAKE)
endmodule
`default_nettype wire

// ----- src/sha_core.sv -----
// Back end: 64-round compression, chaining and digest output.
`default_nettype none
module sha_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sha_pkg::blk_req_t req,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word,
  output logic               out_valid,
  input  wire logic          out_ready
);
  import sha_pkg::*;

  be_state_t st_r, st_nxt;
  word_t     h_r [8];
  word_t     v_r [8];
  word_t     w_r [16];
  logic [5:0] rnd_r;
  logic      emit_r;
  logic [2:0] idx_r;
  word_t     wr, t1, t2, w15, w2, s0, s1;

  assign req_ready = (st_r == BE_IDLE);
  assign out_valid = (st_r == BE_EMIT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  // One round per cycle on a sliding 16-word schedule window
  always_comb begin
    w15 = w_r[1]; w2 = w_r[14];
    s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    wr = w_r[0];
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
         + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_r) + wr;
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BE_IDLE:  if (req_valid) st_nxt = BE_ROUND;
      BE_ROUND: if (rnd_r == 6'd63) st_nxt = BE_FOLD;
      BE_FOLD:  st_nxt = emit_r ? BE_EMIT : BE_IDLE;
      BE_EMIT:  if (out_ready && idx_r == 3'd7) st_nxt = BE_IDLE;
      default:  st_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BE_IDLE; rnd_r <= '0; idx_r <= '0; emit_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= Iv[i];
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        BE_IDLE: if (req_valid) begin
          rnd_r <= '0; emit_r <= req.emit; idx_r <= '0;
        end
        BE_ROUND: rnd_r <= rnd_r + 6'd1;
        BE_FOLD: for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        BE_EMIT: if (out_ready) begin
          idx_r <= idx_r + 3'd1;
          if (idx_r == 3'd7) for (int i = 0; i < 8; i++) h_r[i] <= Iv[i];
        end
        default: ;
      endcase
    end
  end

  // Datapath: load window and working variables, then advance
  always_ff @(posedge clk) begin
    if (st_r == BE_IDLE && req_valid) begin
      for (int i = 0; i < 16; i++) w_r[i] <= req.block[511-32*i -: 32];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (st_r == BE_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_r[0] + s0 + w_r[9] + s1;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMP(a_emit_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid)
  `ASSERT_IMP(a_round_end, clk, rst_n, st_r == BE_ROUND && rnd_r == 6'd63, ##1 st_r == BE_FOLD)
  `ASSERT_IMP(a_no_take_busy, clk, rst_n, st_r != BE_IDLE, !req_ready)
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for the SHA-256 byte stream hasher: random and directed messages.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // Expected digest word as it should leave the out_ channel.
  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic [7:0]  in_data_byte;
  logic        in_byte_valid;
  logic        in_last_byte;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  logic        out_valid;
  logic        out_ready;

  digest_word_t expected_words[$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  bit           idle_enable;

  // Predictor state.
  logic [31:0] hash_state[8];
  logic [7:0]  pending_block[64];
  int unsigned pending_count;
  logic [63:0] compressed_bits;

  sha256_byte_stream_hasher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_data_byte(in_data_byte), .in_byte_valid(in_byte_valid),
    .in_last_byte(in_last_byte), .in_valid(in_valid), .in_ready(in_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word), .out_valid(out_valid), .out_ready(out_ready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over the pending block and fold into the hash state.
  task automatic compress_pending();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    logic [31:0] k_tab[64];
    k_tab = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    for (int j = 0; j < 16; j++)
      w[j] = {pending_block[4*j], pending_block[4*j+1], pending_block[4*j+2],
              pending_block[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = w[j-16] + s0 + w[j-7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = hash_state[j];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] += v[j];
  endtask

  task automatic start_digest();
    for (int j = 0; j < 8; j++) hash_state[j] = Iv[j];
    pending_count = 0;
    compressed_bits = '0;
  endtask

  // Advance the predictor by one request; queue the digest on a last byte.
  task automatic predict_request(input logic [7:0] b, input logic bv, input logic lb);
    logic [63:0] total;
    int unsigned i;
    digest_word_t dw;
    if (bv) begin
      pending_block[pending_count] = b;
      pending_count++;
      if (pending_count == 64) begin
        compress_pending();
        compressed_bits += 64'd512;
        pending_count = 0;
      end
    end
    if (lb) begin
      total = compressed_bits + 64'(pending_count) * 8;
      i = pending_count;
      pending_block[i++] = 8'h80;
      if (i > 56) begin
        while (i < 64) pending_block[i++] = 8'h00;
        compress_pending();
        i = 0;
      end
      while (i < 56) pending_block[i++] = 8'h00;
      for (int j = 0; j < 8; j++) pending_block[56 + j] = total[63 - 8*j -: 8];
      compress_pending();
      for (int j = 0; j < 8; j++) begin
        dw.digest_word = hash_state[j];
        dw.word_index = 3'(j);
        dw.last_word = (j == 7);
        expected_words = {expected_words, dw};
      end
      start_digest();
    end
  endtask

  // Present one request, with an occasional random gap ahead of it, and wait for acceptance.
  task automatic send_request(input logic [7:0] b, input logic bv, input logic lb);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data_byte <= b;
    in_byte_valid <= bv;
    in_last_byte <= lb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(b, bv, lb);
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len, input bit end_with_byte);
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, end_with_byte && n == len - 1);
    end
    if (!end_with_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Drop the input and hold until every expected word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // Empty message, both extremes of byte value, idle items.
  task automatic test_directed();
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'ha5, 1'b0, 1'b1);
  endtask

  // Lengths around the one- and two-block padding boundaries.
  task automatic test_pad_boundaries();
    int unsigned lens[4] = '{55, 56, 64, 63};
    foreach (lens[j]) send_message(lens[j], j % 2 == 0);
  endtask

  // Hold off the sender until every digest word has arrived.
  task automatic test_drain_pause();
    send_message(3, 1'b1);
    wait_drained();
    send_message(1, 1'b0);
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 20) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
      send_message(len, $urandom_range(0, 1));
      sent += len + 1;
    end
  endtask

  // Random backpressure on the result side.
  always @(negedge clk) begin
    if (idle_enable && out_ready && $urandom_range(0, 3) == 0) out_ready <= 1'b0;
    else if (!out_ready && (!idle_enable || $urandom_range(0, 1) == 0)) out_ready <= 1'b1;
  end

  // Check each accepted digest word against the oldest expectation.
  always @(posedge clk) begin
    digest_word_t dw;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected digest word %h", out_digest_word);
      end else begin
        dw = expected_words.pop_front();
        if (out_digest_word !== dw.digest_word || out_word_index !== dw.word_index ||
            out_last_word !== dw.last_word) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", dw.digest_word,
                     dw.word_index, dw.last_word, out_digest_word, out_word_index,
                     out_last_word);
        end
      end
    end
  end

  // Drop the run on a timeout.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_byte_valid = 1'b0;
    in_last_byte = 1'b0;
    out_ready = 1'b1;
    idle_enable = 1'b1;
    mismatch_count = 0;
    cycle_count = 0;
    start_digest();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pad_boundaries();
    test_drain_pause();
    test_random_messages();
    idle_enable = 1'b0;
    send_message(20, 1'b1);
    wait_drained();
    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/sha_pkg.sv
src/sha_front.sv
src/sha_core.sv
src/sha256_byte_stream_hasher.sv
test/tb.sv
